// ----- src/sha256_pkg.sv -----
`default_nettype none

package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // index 0 is a, index 7 is h
  typedef logic [7:0][31:0] hvec_t;

  localparam int BlockBytes = 64;
  localparam int LenPos     = 56;
  localparam logic [7:0] PadMark = 8'h80;

  localparam hvec_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ----- src/sha256_round.sv -----
`default_nettype none

module sha256_round
  import sha256_pkg::*;
(
  input  wire  hvec_t       v,
  input  wire  logic [31:0] k,
  input  wire  logic [31:0] w,
  output hvec_t             v_out
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + bsig1(v[4]) + ch + k + w;
    t2  = bsig0(v[0]) + maj;
    v_out[0] = t1 + t2;
    v_out[1] = v[0];
    v_out[2] = v[1];
    v_out[3] = v[2];
    v_out[4] = v[3] + t1;
    v_out[5] = v[4];
    v_out[6] = v[5];
    v_out[7] = v[6];
  end

endmodule

`default_nettype wire

// ----- src/sha256_hash_core.sv -----
// Channel  Dir  Payload  Handshake             Moves
// in       in   in_t     in_valid / in_ready   one request: byte, byte flag, end flag
// out      out  out_t    out_valid / out_ready one digest word, eight per message
//
// A byte that does not complete a block is just shifted in; a byte completing
// a block triggers 64 rounds on the single round unit and one hash update.
// End of message: padding shifts to the block end, then each padded block
// (one or two) is compressed likewise, then eight output words at one per cycle when out_ready.
// in_ready is high only while idle. Synchronous active-low reset loads the
// initial hash and clears the byte count; no clearing pass.
`default_nettype none

module sha256_hash_core
  import sha256_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  in_t  in_item,
  output logic       out_valid,
  input  wire  logic out_ready,
  output out_t       out_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RND  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [5:0] LastPos = 6'(BlockBytes - 1);
  localparam logic [5:0] LenPos6 = 6'(LenPos);

  logic [2:0]   st_r, st_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [60:0]  cnt_r, cnt_nxt;
  hvec_t        h_r, h_nxt;
  hvec_t        v_r, v_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic         first_r, first_nxt;
  logic         lenblk_r, lenblk_nxt;
  logic         pad_r, pad_nxt;
  logic         lastp_r, lastp_nxt;
  logic [2:0]   idx_r, idx_nxt;

  hvec_t        v_rnd;
  logic [31:0]  w_new;
  logic [63:0]  len_bits;
  logic [7:0]   pad_byte;
  logic [5:0]   pos_now;

  sha256_round u_round (
    .v     (v_r),
    .k     (RoundK[rnd_r]),
    .w     (blk_r[511:480]),
    .v_out (v_rnd)
  );

  assign w_new    = ssig1(blk_r[63:32]) + blk_r[223:192] + ssig0(blk_r[479:448])
                  + blk_r[511:480];
  assign len_bits = {cnt_r, 3'b000};

  always_comb begin
    if (first_r) begin
      pad_byte = PadMark;
    end else if (lenblk_r && (fill_r >= LenPos6)) begin
      pad_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_ready              = (st_r == ST_IDLE);
  assign out_valid             = (st_r == ST_OUT);
  assign out_item.digest_word  = h_r[idx_r];
  assign out_item.word_index   = idx_r;
  assign out_item.last_word    = (idx_r == 3'd7);

  always_comb begin
    st_nxt     = st_r;
    blk_nxt    = blk_r;
    cnt_nxt    = cnt_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    rnd_nxt    = rnd_r;
    fill_nxt   = fill_r;
    first_nxt  = first_r;
    lenblk_nxt = lenblk_r;
    pad_nxt    = pad_r;
    lastp_nxt  = lastp_r;
    idx_nxt    = idx_r;
    pos_now    = cnt_r[5:0];
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.has_byte) begin
            blk_nxt = {blk_r[503:0], in_item.data_byte};
            cnt_nxt = cnt_r + 61'd1;
            pos_now = cnt_r[5:0] + 6'd1;
          end
          if (in_item.has_byte && (cnt_r[5:0] == LastPos)) begin
            st_nxt    = ST_RND;
            v_nxt     = h_r;
            rnd_nxt   = '0;
            lastp_nxt = in_item.last_byte;
          end else if (in_item.last_byte) begin
            st_nxt     = ST_PAD;
            pad_nxt    = 1'b1;
            fill_nxt   = pos_now;
            first_nxt  = 1'b1;
            lenblk_nxt = (pos_now < LenPos6);
          end
        end
      end
      ST_PAD: begin
        blk_nxt   = {blk_r[503:0], pad_byte};
        first_nxt = 1'b0;
        fill_nxt  = fill_r + 6'd1;
        if (fill_r == LastPos) begin
          st_nxt  = ST_RND;
          v_nxt   = h_r;
          rnd_nxt = '0;
        end
      end
      ST_RND: begin
        v_nxt   = v_rnd;
        blk_nxt = {blk_r[479:0], w_new};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LastPos) begin
          st_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (pad_r) begin
          if (lenblk_r) begin
            st_nxt  = ST_OUT;
            idx_nxt = '0;
          end else begin
            st_nxt     = ST_PAD;
            fill_nxt   = '0;
            first_nxt  = 1'b0;
            lenblk_nxt = 1'b1;
          end
        end else if (lastp_r) begin
          st_nxt     = ST_PAD;
          pad_nxt    = 1'b1;
          lastp_nxt  = 1'b0;
          fill_nxt   = cnt_r[5:0];
          first_nxt  = 1'b1;
          lenblk_nxt = 1'b1;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            st_nxt  = ST_IDLE;
            h_nxt   = HashInit;
            cnt_nxt = '0;
            pad_nxt = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      h_r      <= HashInit;
      rnd_r    <= '0;
      fill_r   <= '0;
      first_r  <= 1'b0;
      lenblk_r <= 1'b0;
      pad_r    <= 1'b0;
      lastp_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      h_r      <= h_nxt;
      rnd_r    <= rnd_nxt;
      fill_r   <= fill_nxt;
      first_r  <= first_nxt;
      lenblk_r <= lenblk_nxt;
      pad_r    <= pad_nxt;
      lastp_r  <= lastp_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

endmodule

`default_nettype wire

// ----- src/sha256_chk.sv -----
`default_nettype none

module sha256_chk
  import sha256_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_item,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_item
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("intake open while digest pending");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last_word |=>
      out_valid && (out_item.word_index == 3'($past(out_item.word_index) + 3'd1)))
    else $error("digest words out of sequence");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.last_word |=> in_ready)
    else $error("not idle after final digest word");

  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_item.has_byte && !in_item.last_byte |=> in_ready)
    else $error("empty request left the core busy");

endmodule

bind sha256_hash_core sha256_chk u_chk (.*);

`default_nettype wire
